FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on clock, disabled while reset is high except in the ALWAYS variant
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property at every rising clock edge outside reset
`define BKD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same check, also active during reset
`define BKD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define BKD_ASSERT(lbl, prop, msg)
`define BKD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: rtl/bkd_pkg.sv
// ----------------------------------------------------------------------------
// bkd_pkg
// shared types, register codes and constants of the backoff delay pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bkd_pkg;

   localparam int REASON_W  = 8;
   localparam int COUNT_W   = 8;
   localparam int RND_W     = 16;
   localparam int BASE_W    = 16;
   localparam int CAP_W     = 20;
   localparam int JIT_W     = 16;
   localparam int DIV_W     = JIT_W + 1;
   localparam int DELAY_W   = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 20;

   localparam int DEF_MAX_RETRY_SHIFT = 16;

   // remainder unit: restoring steps per pipeline stage
   localparam int DIV_STEPS  = 4;
   localparam int DIV_STAGES = RND_W / DIV_STEPS;

   localparam logic [REASON_W-1:0] AUTH_LO_A = 8'd15;
   localparam logic [REASON_W-1:0] AUTH_HI_A = 8'd24;
   localparam logic [REASON_W-1:0] AUTH_LO_B = 8'd202;
   localparam logic [REASON_W-1:0] AUTH_HI_B = 8'd205;

   localparam int AUTH_THRESHOLD = 3;
   localparam int FAST_THRESHOLD = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_BASE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_CAP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_JITTER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_BASE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_CAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_JITTER = 3'd5;

   // register reset values
   localparam logic [BASE_W-1:0] RST_SLOW_BASE   = 16'd5000;
   localparam logic [CAP_W-1:0]  RST_SLOW_CAP    = 20'd30000;
   localparam logic [JIT_W-1:0]  RST_SLOW_JITTER = 16'd1000;
   localparam logic [BASE_W-1:0] RST_FAST_BASE   = 16'd500;
   localparam logic [CAP_W-1:0]  RST_FAST_CAP    = 20'd8000;
   localparam logic [JIT_W-1:0]  RST_FAST_JITTER = 16'd250;

   typedef struct packed {
      logic [BASE_W-1:0] slow_base;
      logic [CAP_W-1:0]  slow_cap;
      logic [JIT_W-1:0]  slow_jitter;
      logic [BASE_W-1:0] fast_base;
      logic [CAP_W-1:0]  fast_cap;
      logic [JIT_W-1:0]  fast_jitter;
   } cfg_type;

   // one request in flight through the pipeline
   typedef struct packed {
      logic              auth;
      logic [CAP_W-1:0]  delay_base;
      logic [DIV_W-1:0]  divisor;
      logic [RND_W-1:0]  dividend;
      logic [JIT_W-1:0]  rem;
   } pipe_type;

endpackage

FILE: rtl/bkd_if.sv
// ----------------------------------------------------------------------------
// bkd_if
// request and response channels of the backoff delay block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bkd_req_if
   import bkd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [REASON_W-1:0] reason_code;
   logic [COUNT_W-1:0]  retry_count;
   logic [RND_W-1:0]    random_value;

   modport source (output valid, output reason_code, output retry_count,
                   output random_value, input ready);
   modport sink   (input valid, input reason_code, input retry_count,
                   input random_value, output ready);
endinterface

interface bkd_rsp_if
   import bkd_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [DELAY_W-1:0] delay_ms;
   logic               auth_failure;

   modport source (output valid, output delay_ms, output auth_failure, input ready);
   modport sink   (input valid, input delay_ms, input auth_failure, output ready);
endinterface

FILE: rtl/bkd_front.sv
// ----------------------------------------------------------------------------
// bkd_front
// reason classing, count clamp, base shift and cap select, first stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkd_front
   import bkd_pkg::*;
#(
   parameter int MAX_RETRY_SHIFT = DEF_MAX_RETRY_SHIFT
) (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [REASON_W-1:0] reason_code,
   input  logic [COUNT_W-1:0]  retry_count,
   input  logic [RND_W-1:0]    random_value,
   output logic                out_valid,
   input  logic                out_ready,
   output pipe_type            out_data
);

   localparam int CNT_W   = $clog2(MAX_RETRY_SHIFT + 1);
   localparam int SHIFT_W = BASE_W + MAX_RETRY_SHIFT;

   logic               valid_ff;
   pipe_type           data_ff;
   pipe_type           data_in;
   logic               auth;
   logic [CNT_W-1:0]   cnt;
   logic [BASE_W-1:0]  base;
   logic [CAP_W-1:0]   cap;
   logic [JIT_W-1:0]   jitter;
   logic [CNT_W-1:0]   thr;
   logic [SHIFT_W-1:0] shifted;
   logic               use_cap;

   always_comb begin
      auth = ((reason_code >= AUTH_LO_A) && (reason_code <= AUTH_HI_A)) ||
             ((reason_code >= AUTH_LO_B) && (reason_code <= AUTH_HI_B));
      if (retry_count > COUNT_W'(MAX_RETRY_SHIFT)) begin
         cnt = CNT_W'(MAX_RETRY_SHIFT);
      end else begin
         cnt = retry_count[CNT_W-1:0];
      end
      base   = auth ? cfg.slow_base   : cfg.fast_base;
      cap    = auth ? cfg.slow_cap    : cfg.fast_cap;
      jitter = auth ? cfg.slow_jitter : cfg.fast_jitter;
      thr    = auth ? CNT_W'(AUTH_THRESHOLD) : CNT_W'(FAST_THRESHOLD);
      shifted = SHIFT_W'(base) << cnt;
      use_cap = (cnt >= thr) || (shifted > SHIFT_W'(cap));

      data_in.auth       = auth;
      // below the cap the shifted base fits the cap width
      data_in.delay_base = use_cap ? cap : shifted[CAP_W-1:0];
      data_in.divisor    = DIV_W'(jitter) + DIV_W'(1);
      data_in.dividend   = random_value;
      data_in.rem        = '0;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/bkd_div_stage.sv
// ----------------------------------------------------------------------------
// bkd_div_stage
// one stage of the pipelined remainder unit, DIV_STEPS (4) restoring steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkd_div_stage
   import bkd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   always_comb begin
      logic [DIV_W-1:0] trial;
      data_in = in_data;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial = {data_in.rem, data_in.dividend[RND_W-1]};
         data_in.dividend = data_in.dividend << 1;
         if (trial >= data_in.divisor) begin
            trial = trial - data_in.divisor;
         end
         // remainder stays below the divisor, so it fits the jitter width
         data_in.rem = trial[JIT_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/bkd_out.sv
// ----------------------------------------------------------------------------
// bkd_out
// jitter add and response register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bkd_out
   import bkd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  pipe_type  in_data,
   bkd_rsp_if.source rsp
);

   logic               valid_ff;
   logic [DELAY_W-1:0] delay_ff;
   logic [DELAY_W-1:0] delay_in;
   logic               auth_ff;

   assign delay_in = DELAY_W'(in_data.delay_base) + DELAY_W'(in_data.rem);
   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         delay_ff <= delay_in;
         auth_ff  <= in_data.auth;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.delay_ms     = delay_ff;
   assign rsp.auth_failure = auth_ff;

endmodule

FILE: rtl/reconnect_backoff_delay_top.sv
// ----------------------------------------------------------------------------
// reconnect_backoff_delay_top: exponential reconnect backoff with jitter
// a request passes the front, remainder and response registers; one request a cycle unless the response stalls
// the 4-stage remainder pipeline does 4 restoring steps a stage
// synchronous reset clears all stage valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module reconnect_backoff_delay_top
   import bkd_pkg::*;
#(
   parameter int MAX_RETRY_SHIFT = DEF_MAX_RETRY_SHIFT
) (
   input  logic                 clock,
   input  logic                 reset,
   bkd_req_if.sink              req_chan,
   bkd_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // configuration registers, to be written only while the pipeline is empty; not enforced here
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_base   <= RST_SLOW_BASE;
         cfg_ff.slow_cap    <= RST_SLOW_CAP;
         cfg_ff.slow_jitter <= RST_SLOW_JITTER;
         cfg_ff.fast_base   <= RST_FAST_BASE;
         cfg_ff.fast_cap    <= RST_FAST_CAP;
         cfg_ff.fast_jitter <= RST_FAST_JITTER;
      end else if (csr_we) begin
         case (csr_index)
            REG_SLOW_BASE:   cfg_ff.slow_base   <= csr_wdata[BASE_W-1:0];
            REG_SLOW_CAP:    cfg_ff.slow_cap    <= csr_wdata[CAP_W-1:0];
            REG_SLOW_JITTER: cfg_ff.slow_jitter <= csr_wdata[JIT_W-1:0];
            REG_FAST_BASE:   cfg_ff.fast_base   <= csr_wdata[BASE_W-1:0];
            REG_FAST_CAP:    cfg_ff.fast_cap    <= csr_wdata[CAP_W-1:0];
            REG_FAST_JITTER: cfg_ff.fast_jitter <= csr_wdata[JIT_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // stage 0 is the front register, stages 1..DIV_STAGES the remainder unit
   pipe_type stage_data  [DIV_STAGES+1];
   logic     stage_valid [DIV_STAGES+1];
   logic     stage_ready [DIV_STAGES+1];
   logic     full_stall;

   // front: class the reason, clamp the count, pick base or cap
   bkd_front #(
      .MAX_RETRY_SHIFT (MAX_RETRY_SHIFT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .reason_code  (req_chan.reason_code),
      .retry_count  (req_chan.retry_count),
      .random_value (req_chan.random_value),
      .out_valid    (stage_valid[0]),
      .out_ready    (stage_ready[0]),
      .out_data     (stage_data[0])
   );

   // random value modulo (jitter + 1), DIV_STEPS quotient bits per stage
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      bkd_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[k]),
         .in_ready  (stage_ready[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_ready (stage_ready[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // add the jitter and hold the response until taken
   bkd_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[DIV_STAGES]),
      .in_ready (stage_ready[DIV_STAGES]),
      .in_data  (stage_data[DIV_STAGES]),
      .rsp      (rsp_chan)
   );

   // every stage holds a request and the response is not taken
   always_comb begin
      full_stall = rsp_chan.valid && !rsp_chan.ready;
      for (int k = 0; k <= DIV_STAGES; k++) begin
         full_stall = full_stall && stage_valid[k];
      end
   end

   // a full, stalled pipeline must refuse a new request
   `BKD_ASSERT(a_no_accept_when_full, full_stall |-> !req_chan.ready, "request accepted into full pipeline")

   // divisor is jitter plus one and never zero
   `BKD_ASSERT(a_divisor_nonzero, stage_valid[0] |-> (stage_data[0].divisor != '0), "zero divisor in pipeline")

   // finished remainder is below the divisor
   `BKD_ASSERT(a_rem_below_div, stage_valid[DIV_STAGES] |-> (DIV_W'(stage_data[DIV_STAGES].rem) < stage_data[DIV_STAGES].divisor), "remainder not below divisor")

   // a stalled front stage keeps its request
   `BKD_ASSERT(a_front_hold, (stage_valid[0] && !stage_ready[0]) |=> (stage_valid[0] && $stable(stage_data[0])), "front stage lost a stalled request")

endmodule
